### sv/chfm_pkg.sv
// Package for the compass heading block: widths, binary-angle constants,
// register indexes, pipeline payload types and the arctangent table.
// Depends on nothing; every other file takes names from here.
package chfm_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int SCALE_FRAC_BITS_DEF = 14;

  // Field widths.
  localparam int RAW_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int HEAD_W    = 16;

  // Datapath widths: raw minus offset, corrected axis, CORDIC vector and angle.
  localparam int DIFF_W   = RAW_W + 1;
  localparam int CORR_W   = DIFF_W + CFG_W;
  localparam int PRESHIFT = 24;
  localparam int XY_W     = CORR_W + PRESHIFT + 3;
  localparam int ANG_W    = 32;
  localparam int PROD_W   = ANG_W + HEAD_W;
  localparam int TAB_LEN  = 24;

  // Binary-angle bases (a full turn is 2^32) and bearing constants.
  localparam logic [ANG_W-1:0]  ANG_90     = 32'h4000_0000;
  localparam logic [ANG_W-1:0]  ANG_270    = 32'hC000_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h8000_0000);
  localparam logic [HEAD_W-1:0] HEAD_TURN  = 16'd36000;
  localparam logic [HEAD_W-1:0] HEAD_SOUTH = 16'd18000;
  localparam logic [HEAD_W-1:0] HEAD_NORTH = 16'd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 8'd0,
    REG_OFFSET_Y = 8'd1,
    REG_SCALE_X  = 8'd2,
    REG_SCALE_Y  = 8'd3
  } reg_idx_t;

  // Facts about the corrected sample that the final stage needs.
  typedef struct packed {
    logic cy_zero;
    logic cy_pos;
    logic cx_neg;
    logic cx_zero;
  } flags_t;

  // Payload that moves from cell to cell.
  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [ANG_W-1:0] z;
    flags_t           flags;
  } vec_t;

  // atan(2^-i) in binary-angle units, rounded to nearest.
  function automatic logic [ANG_W-1:0] atan_entry(input int step);
    logic [ANG_W-1:0] a;
    case (step)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### sv/chfm_if.sv
// Stream interfaces of the compass heading block: raw samples in,
// headings out, and the configuration write channel.
// Depends on chfm_pkg for the field widths.
interface chfm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [chfm_pkg::RAW_W-1:0]   raw_x;
  logic signed [chfm_pkg::RAW_W-1:0]   raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface chfm_heading_if;
  logic                         valid;
  logic                         ready;
  logic [chfm_pkg::HEAD_W-1:0]  heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

interface chfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [chfm_pkg::CFG_IDX_W-1:0]  index;
  logic [chfm_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/compass_heading_from_magnetometer.sv
// Compass heading: three front stages, one cell per CORDIC step (up to the
// arctangent table length) and two back stages. Throughput is one
// transaction per cycle while the output is not stalled; every stage has its
// own valid bit, so a stalled result holds only the stages behind it that are full.
// Synchronous reset empties the pipeline, clears offsets to 0 and sets both
// gains to 1.0; configuration writes are taken in every cycle.
module compass_heading_from_magnetometer #(
  parameter int CORDIC_STEPS    = chfm_pkg::CORDIC_STEPS_DEF,
  parameter int SCALE_FRAC_BITS = chfm_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  chfm_sample_if.sink     sample,
  chfm_heading_if.source  bearing,
  chfm_cfg_if.sink        cfg
);

  localparam int NCELL = (CORDIC_STEPS > chfm_pkg::TAB_LEN) ? chfm_pkg::TAB_LEN : CORDIC_STEPS;
  localparam logic [chfm_pkg::CFG_W-1:0] SCALE_ONE =
    chfm_pkg::CFG_W'(64'd1 << SCALE_FRAC_BITS);

  logic [chfm_pkg::CFG_W-1:0] offset_x, offset_y, scale_x, scale_y;

  logic           cell_valid [NCELL+1];
  logic           cell_ready [NCELL+1];
  chfm_pkg::vec_t cell_vec   [NCELL+1];

  // Configuration registers; the channel never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      scale_x  <= SCALE_ONE;
      scale_y  <= SCALE_ONE;
    end else if (cfg.valid) begin
      case (chfm_pkg::reg_idx_t'(cfg.index))
        chfm_pkg::REG_OFFSET_X: offset_x <= cfg.data;
        chfm_pkg::REG_OFFSET_Y: offset_y <= cfg.data;
        chfm_pkg::REG_SCALE_X:  scale_x  <= cfg.data;
        chfm_pkg::REG_SCALE_Y:  scale_y  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Offset, gain and vector setup.
  chfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .raw_x     (sample.raw_x),
    .raw_y     (sample.raw_y),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_vec   (cell_vec[0])
  );

  // Row of CORDIC cells, one per step.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    chfm_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_vec    (cell_vec[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_vec   (cell_vec[i+1])
    );
  end

  // Angle to bearing and output register.
  chfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[NCELL]),
    .in_ready  (cell_ready[NCELL]),
    .in_vec    (cell_vec[NCELL]),
    .out_valid (bearing.valid),
    .out_ready (bearing.ready),
    .heading   (bearing.heading)
  );

endmodule

### sv/chfm_front.sv
// Front end: hard-iron offset removal, gain multiply and CORDIC vector setup,
// three registered stages with per-stage handshake.
// Depends on chfm_pkg.
module chfm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [chfm_pkg::RAW_W-1:0]    raw_x,
  input  logic signed [chfm_pkg::RAW_W-1:0]    raw_y,
  input  logic        [chfm_pkg::CFG_W-1:0]    offset_x,
  input  logic        [chfm_pkg::CFG_W-1:0]    offset_y,
  input  logic        [chfm_pkg::CFG_W-1:0]    scale_x,
  input  logic        [chfm_pkg::CFG_W-1:0]    scale_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output chfm_pkg::vec_t                       out_vec
);

  localparam int DW = chfm_pkg::DIFF_W;
  localparam int CW = chfm_pkg::CORR_W;
  localparam int XW = chfm_pkg::XY_W;

  logic                 v0, v1;
  logic                 rdy0, rdy1, rdy2;
  logic signed [DW-1:0] dx, dy;
  logic signed [CW-1:0] cx, cy;
  logic signed [DW+DW-1:0] cx_full, cy_full;
  logic signed [XW-1:0] cx_ext, cy_ext, vx, vy;
  chfm_pkg::flags_t     flags;
  chfm_pkg::vec_t       vec_next;

  // A stage takes a new transaction when it is empty or its contents move on.
  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  // Corrected axes: the gain is unsigned, so it gets a zero sign bit.
  assign cx_full = dx * $signed({1'b0, scale_x});
  assign cy_full = dy * $signed({1'b0, scale_y});

  // Set up the vector so that its x component is non-negative.
  always_comb begin
    flags.cy_zero = (cy == '0);
    flags.cy_pos  = !cy[CW-1] && (cy != '0);
    flags.cx_neg  = cx[CW-1];
    flags.cx_zero = (cx == '0);
    cx_ext = XW'(cx);
    cy_ext = XW'(cy);
    vx = (cy[CW-1] ? -cy_ext : cy_ext) <<< chfm_pkg::PRESHIFT;
    vy = (flags.cy_pos ? cx_ext : -cx_ext) <<< chfm_pkg::PRESHIFT;
    vec_next.x     = vx;
    vec_next.y     = vy;
    vec_next.z     = '0;
    vec_next.flags = flags;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) out_valid <= v1;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      dx <= DW'(raw_x) - DW'($signed(offset_x));
      dy <= DW'(raw_y) - DW'($signed(offset_y));
    end
    if (rdy1 && v0) begin
      cx <= cx_full[CW-1:0];
      cy <= cy_full[CW-1:0];
    end
    if (rdy2 && v1) begin
      out_vec <= vec_next;
    end
  end

endmodule

### sv/chfm_cordic_cell.sv
// One CORDIC vectoring cell: a fixed shift by its step number, one add and
// one subtract on the vector, and the step's arctangent into the angle.
// Depends on chfm_pkg for the payload type and the arctangent table.
module chfm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  chfm_pkg::vec_t  in_vec,
  output logic            out_valid,
  input  logic            out_ready,
  output chfm_pkg::vec_t  out_vec
);

  localparam int XW = chfm_pkg::XY_W;
  localparam logic [chfm_pkg::ANG_W-1:0] ANGLE = chfm_pkg::atan_entry(STEP);

  logic signed [XW-1:0] x, y, dx, dy;
  chfm_pkg::vec_t       vec_next;

  assign in_ready = !out_valid || out_ready;

  // Rotate toward the x axis; arithmetic shifts round toward minus infinity.
  always_comb begin
    x  = in_vec.x;
    y  = in_vec.y;
    dx = y >>> STEP;
    dy = x >>> STEP;
    vec_next.flags = in_vec.flags;
    if (!y[XW-1]) begin
      vec_next.x = x + dx;
      vec_next.y = y - dy;
      vec_next.z = in_vec.z + ANGLE;
    end else begin
      vec_next.x = x - dx;
      vec_next.y = y + dy;
      vec_next.z = in_vec.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_vec <= vec_next;
    end
  end

endmodule

### sv/chfm_back.sv
// Back end: adds the quadrant base to the CORDIC angle, scales binary angle to
// hundredths of a degree, rounds, wraps and handles the zero-Y cases.
// Depends on chfm_pkg.
module chfm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  chfm_pkg::vec_t               in_vec,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [chfm_pkg::HEAD_W-1:0]  heading
);

  localparam int AW = chfm_pkg::ANG_W;
  localparam int PW = chfm_pkg::PROD_W;
  localparam int HW = chfm_pkg::HEAD_W;

  logic          va;
  logic          rdy_a, rdy_b;
  logic [AW-1:0] base, angle, bearing;
  logic [PW-1:0] prod, prod_a, rounded;
  logic          cy_zero_a, cx_neg_a;
  logic [HW-1:0] h, heading_next;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // Bearing in binary angle; an axis-aligned X contributes no arctangent.
  always_comb begin
    base    = in_vec.flags.cy_pos ? chfm_pkg::ANG_270 : chfm_pkg::ANG_90;
    angle   = in_vec.flags.cx_zero ? '0 : in_vec.z;
    bearing = base + angle;
    prod    = PW'(bearing) * PW'(chfm_pkg::HEAD_TURN);
  end

  // Round to nearest, wrap a full turn to zero, and cover the zero-Y case.
  always_comb begin
    rounded = prod_a + chfm_pkg::ROUND_HALF;
    h       = rounded[PW-1:AW];
    if (cy_zero_a) begin
      heading_next = cx_neg_a ? chfm_pkg::HEAD_SOUTH : chfm_pkg::HEAD_NORTH;
    end else if (h >= chfm_pkg::HEAD_TURN) begin
      heading_next = chfm_pkg::HEAD_NORTH;
    end else begin
      heading_next = h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      prod_a    <= prod;
      cy_zero_a <= in_vec.flags.cy_zero;
      cx_neg_a  <= in_vec.flags.cx_neg;
    end
    if (rdy_b && va) begin
      heading <= heading_next;
    end
  end

endmodule

### sv/chfm_checker.sv
// Port-level checks for the compass heading block, bound to the top level.
// Depends on chfm_pkg and on the top level's interface ports.
module chfm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [chfm_pkg::HEAD_W-1:0]  heading
);

  // A delivered heading is always inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading < chfm_pkg::HEAD_TURN))
    else $error("heading outside 0..35999");

  // With the output register empty nothing can hold back the input side.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result keeps its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(heading)))
    else $error("stalled heading changed");

endmodule

bind compass_heading_from_magnetometer chfm_checker u_chfm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (bearing.valid),
  .out_ready (bearing.ready),
  .heading   (bearing.heading)
);

### test/tb_compass_heading_from_magnetometer.sv
// Testbench for compass_heading_from_magnetometer: a queue-fed driver, a monitor
// that predicts every bearing with its own CORDIC, random idling and stalls.
// Depends on chfm_pkg and the stream interfaces in chfm_if.sv.
module tb_compass_heading_from_magnetometer;
  timeunit 1ns;
  timeprecision 1ps;
  import chfm_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int STEPS_USED   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int LATENCY      = CORDIC_STEPS + 5;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 85;
  localparam int NUM_PHASES   = 8;

  // An index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 8'd4;

  // Binary-angle bases and bearings in hundredths of a degree.
  localparam logic [31:0] BASE_EAST_HALF = 32'h4000_0000;
  localparam logic [31:0] BASE_WEST_HALF = 32'hC000_0000;
  localparam int          FULL_TURN_CD   = 36000;
  localparam int          SOUTH_CD       = 18000;
  localparam int          NORTH_CD       = 0;
  localparam logic [15:0] UNITY_GAIN     = 16'd16384;

  // atan(2^-i) in binary-angle units (2^32 is a full turn).
  localparam logic [31:0] ATAN_LUT [0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
  } sample_t;

  typedef struct {
    logic [HEAD_W-1:0]       heading;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
  } heading_expect_t;

  logic clk;
  logic rst;

  chfm_sample_if  smp();
  chfm_heading_if hd();
  chfm_cfg_if     cfg();

  compass_heading_from_magnetometer #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .bearing(hd),
    .cfg    (cfg)
  );

  // Mirror of the calibration registers, updated on each accepted write.
  logic signed [CFG_W-1:0] off_x, off_y;
  logic [CFG_W-1:0]        gain_x, gain_y;

  sample_t         samples_pending[$];
  heading_expect_t headings_due[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  bit          smp_fire;
  int          quiet_cycles;
  int          samples_taken;
  int          headings_seen;
  int          mismatches;
  int          settings_used;

  // Bearing of one raw sample under the current calibration.
  function automatic logic [HEAD_W-1:0] bearing_of(logic signed [RAW_W-1:0] rx,
                                                   logic signed [RAW_W-1:0] ry);
    longint      cx, cy, vx, vy, vz, dx, dy;
    logic [31:0] base, ang;
    logic [63:0] prod;
    logic [31:0] cd;
    cx = (longint'(rx) - longint'(off_x)) * longint'(gain_x);
    cy = (longint'(ry) - longint'(off_y)) * longint'(gain_y);
    if (cy == 0) begin
      return (cx < 0) ? HEAD_W'(SOUTH_CD) : HEAD_W'(NORTH_CD);
    end
    base = (cy > 0) ? BASE_WEST_HALF : BASE_EAST_HALF;
    vz = 0;
    // Vectoring CORDIC: rotate (|cy|, +-cx) onto the positive x axis.
    if (cx != 0) begin
      vx = ((cy > 0) ? cy : -cy) <<< 24;
      vy = ((cy > 0) ? cx : -cx) <<< 24;
      for (int i = 0; i < STEPS_USED; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          vz = vz + longint'(ATAN_LUT[i]);
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          vz = vz - longint'(ATAN_LUT[i]);
        end
      end
    end
    ang  = base + vz[31:0];
    prod = 64'(ang) * 64'd36000 + 64'h8000_0000;
    cd   = prod[63:32];
    if (cd >= FULL_TURN_CD) begin
      cd = NORTH_CD;
    end
    return cd[HEAD_W-1:0];
  endfunction

  // Random sample, biased so that zero corrected axes show up often.
  function automatic sample_t random_sample();
    sample_t s;
    int      mode;
    mode = $urandom_range(9);
    s.x  = RAW_W'($urandom);
    s.y  = RAW_W'($urandom);
    case (mode)
      6, 7: begin
        s.x = off_x + RAW_W'($urandom_range(8)) - 16'sd4;
        s.y = off_y + RAW_W'($urandom_range(8)) - 16'sd4;
      end
      8: begin
        s.x = off_x;
      end
      9: begin
        s.y = off_y;
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample driver: presents the next pending item at the falling edge.
  always @(negedge clk) begin
    sample_t next_item;
    if (!smp.valid || smp_fire) begin
      if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = samples_pending.pop_front();
        smp.valid <= 1'b1;
        smp.raw_x <= next_item.x;
        smp.raw_y <= next_item.y;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // Heading receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      hd.ready <= 1'b0;
    end else begin
      hd.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: mirrors register writes, predicts accepted samples, checks headings.
  always @(posedge clk) begin
    heading_expect_t exp_h;
    bit              hd_fire;
    bit              cfg_fire;
    smp_fire = !rst && smp.valid && smp.ready;
    hd_fire  = !rst && hd.valid && hd.ready;
    cfg_fire = !rst && cfg.valid && cfg.ready;
    if (cfg_fire) begin
      case (cfg.index)
        REG_OFFSET_X: off_x  = cfg.data;
        REG_OFFSET_Y: off_y  = cfg.data;
        REG_SCALE_X:  gain_x = cfg.data;
        REG_SCALE_Y:  gain_y = cfg.data;
        default: begin
        end
      endcase
    end
    if (smp_fire) begin
      exp_h.heading = bearing_of(smp.raw_x, smp.raw_y);
      exp_h.x       = smp.raw_x;
      exp_h.y       = smp.raw_y;
      headings_due.push_back(exp_h);
      samples_taken++;
    end
    if (hd_fire) begin
      headings_seen++;
      if (headings_due.size() == 0) begin
        $error("heading: unexpected transaction, value %0d", hd.heading);
        mismatches++;
      end else begin
        exp_h = headings_due.pop_front();
        if (hd.heading !== exp_h.heading) begin
          $error("heading: expected %0d, actual %0d (raw_x %0d, raw_y %0d)",
                 exp_h.heading, hd.heading, exp_h.x, exp_h.y);
          mismatches++;
        end
      end
    end
    // Watchdog on stretches with no transaction on any channel.
    if (smp_fire || hd_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles, %0d headings outstanding",
             quiet_cycles, headings_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Writes all four registers back to back, then one write past the list.
  task automatic apply_setting(logic [15:0] ox, logic [15:0] oy,
                               logic [15:0] sx, logic [15:0] sy);
    logic [CFG_IDX_W-1:0] idx [0:4];
    logic [CFG_W-1:0]     val [0:4];
    idx = '{REG_OFFSET_X, REG_OFFSET_Y, REG_SCALE_X, REG_SCALE_Y, REG_PAST_END};
    val = '{ox, oy, sx, sy, CFG_W'($urandom)};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data  <= val[i];
      do @(posedge clk); while (!cfg.ready);
    end
    @(negedge clk);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  // Waits until every queued sample is taken and every heading has arrived.
  task automatic drain();
    do @(posedge clk);
    while (samples_pending.size() != 0 || smp.valid || headings_due.size() != 0);
  endtask

  task automatic queue_sample(int x, int y);
    sample_t s;
    s.x = RAW_W'(x);
    s.y = RAW_W'(y);
    samples_pending.push_back(s);
  endtask

  // Stimulus sequence.
  initial begin
    logic [15:0] ox, oy, sx, sy;
    rst            = 1'b1;
    smp.valid      = 1'b0;
    smp.raw_x      = '0;
    smp.raw_y      = '0;
    hd.ready       = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    smp_fire       = 1'b0;
    quiet_cycles   = 0;
    samples_taken  = 0;
    headings_seen  = 0;
    mismatches     = 0;
    settings_used  = 0;
    off_x          = '0;
    off_y          = '0;
    gain_x         = UNITY_GAIN;
    gain_y         = UNITY_GAIN;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset calibration: axes, quadrants, extremes,
    // and a bearing just short of a full turn that must round to north.
    @(posedge clk);
    queue_sample(0, 0);
    queue_sample(1, 0);
    queue_sample(-1, 0);
    queue_sample(0, 1);
    queue_sample(0, -1);
    queue_sample(1, 1);
    queue_sample(-1, -1);
    queue_sample(1, -1);
    queue_sample(-1, 1);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, 1);
    queue_sample(-32768, -1);
    queue_sample(-1, 32767);
    queue_sample(12345, -2345);
    queue_sample(-20000, 7);
    drain();

    // Extreme offsets with zero Y gain: every bearing is north or south.
    apply_setting(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
    @(posedge clk);
    queue_sample(32767, 5);
    queue_sample(-32768, 0);
    drain();

    // Opposite extreme offsets with maximum gains: largest corrected values.
    apply_setting(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(-32767, 0);
    drain();

    // Random phases, each with its own calibration and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          ox = 16'h0000; oy = 16'h0000; sx = UNITY_GAIN; sy = UNITY_GAIN;
        end
        1: begin
          ox = 16'h7FFF; oy = 16'h8000; sx = 16'h0000; sy = 16'hFFFF;
        end
        default: begin
          ox = ($urandom_range(2) == 0) ? 16'h0000 : 16'($urandom);
          oy = ($urandom_range(2) == 0) ? 16'h0000 : 16'($urandom);
          sx = ($urandom_range(3) == 0) ? UNITY_GAIN : 16'($urandom);
          sy = ($urandom_range(3) == 0) ? UNITY_GAIN : 16'($urandom);
          if ($urandom_range(5) == 0) begin
            sx = 16'h0000;
          end
        end
      endcase
      apply_setting(ox, oy, sx, sy);
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        samples_pending.push_back(random_sample());
      end
      // Long output hold-off while samples keep coming, so the pipe backs up.
      if (p == 4) begin
        hold_req = 1'b1;
      end
      drain();
    end

    // Let the pipeline settle so that any stray heading is caught.
    repeat (2 * LATENCY) @(posedge clk);
    if (headings_due.size() != 0) begin
      $error("heading: %0d expected transactions never arrived", headings_due.size());
      mismatches++;
    end

    $display("Run covered %0d samples and %0d headings across %0d calibration settings,",
             samples_taken, headings_seen, settings_used + 1);
    $display("with idle and stall patterns on both sides and one long output hold-off.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
